@@ rtl/rx_tuner_frame_sequencer_top_macros.svh @@
// assertion helpers for the frame sequencer
`ifndef RX_TUNER_FRAME_SEQUENCER_TOP_MACROS_SVH
`define RX_TUNER_FRAME_SEQUENCER_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define RTFS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define RTFS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/rtfs_pkg.sv @@
`timescale 1ns / 1ps

package rtfs_pkg;

    localparam int unsigned CMD_DEPTH  = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [3:0]  ADDR_FREQ  = 4'd1;
    localparam logic [3:0]  ADDR_POWER = 4'd10;
    localparam logic [3:0]  ADDR_RESET = 4'd15;
    localparam logic [19:0] PD_WORD    = 20'hFFFFF;

    typedef enum logic [1:0] {
        CFG_BUS_GAP         = 2'd0,
        CFG_TUNE_WAIT       = 2'd1,
        CFG_POWER_DOWN_CODE = 2'd2,
        CFG_SETUP_POWER     = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] time_ms;
        logic [12:0] requested_freq_mhz;
        logic [11:0] adc_sample;
        logic [15:0] readback_word;
    } item_t;

    typedef struct packed {
        logic        frame_valid;
        logic [3:0]  frame_address;
        logic        frame_write;
        logic [19:0] frame_data;
        logic [7:0]  rssi_level;
        logic        verify_done;
        logic        verify_ok;
        logic        last;
    } result_t;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_POWER_DOWN = 3'd1,
        CMD_WAKE       = 3'd2,
        CMD_FREQ       = 3'd3,
        CMD_READ       = 3'd4,
        CMD_VERIFY     = 3'd5
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [15:0] freq_word;
        logic [19:0] power_word;
        logic [7:0]  rssi;
        logic        ok;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ rtl/rtfs_front.sv @@
`timescale 1ns / 1ps

module rtfs_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  rtfs_pkg::item_t                  item,
    input  logic                             write_enable,
    input  logic [rtfs_pkg::CFG_IDX_W-1:0]   write_index,
    input  logic [rtfs_pkg::CFG_DATA_W-1:0]  write_data,
    input  rtfs_pkg::q_status_t              q_stat,
    output logic                             cmd_push,
    output rtfs_pkg::cmd_t                   cmd
);

    logic [9:0]  bus_gap_reg;
    logic [9:0]  tune_wait_reg;
    logic [12:0] pd_code_reg;
    logic [19:0] setup_word_reg;

    logic [12:0] cur_freq_reg, cur_freq_next;
    logic [31:0] last_change_reg, last_change_next;
    logic        tuning_reg, tuning_next;
    logic        powered_down_reg, powered_down_next;
    logic        pending_reg, pending_next;

    logic [31:0] elapsed;
    logic        gap_ok;
    logic        wait_ok;
    logic        accept;

    function automatic logic [15:0] freq_word_f(input logic [12:0] f);
        logic [12:0] fc;
        logic [12:0] diff;
        logic [11:0] t;
        fc   = (f < 13'd479) ? 13'd479 : f;
        diff = fc - 13'd479;
        t    = diff[12:1];
        return {2'b00, t[11:5], 2'b00, t[4:0]};
    endfunction

    assign full     = q_stat.full;
    assign accept   = push && !q_stat.full;
    assign cmd_push = accept && (!item.kind || pending_reg);

    always_comb
    begin
        elapsed           = item.time_ms - last_change_reg;
        gap_ok            = elapsed > {22'd0, bus_gap_reg};
        wait_ok           = elapsed > {22'd0, tune_wait_reg};
        cur_freq_next     = cur_freq_reg;
        last_change_next  = last_change_reg;
        tuning_next       = tuning_reg;
        powered_down_next = powered_down_reg;
        pending_next      = pending_reg;
        cmd.op            = rtfs_pkg::CMD_NONE;
        cmd.freq_word     = freq_word_f(item.requested_freq_mhz);
        cmd.power_word    = setup_word_reg;
        cmd.ok            = 1'b0;
        cmd.rssi          = 8'd0;
        if (item.kind)
        begin
            cmd.op       = rtfs_pkg::CMD_VERIFY;
            cmd.ok       = (item.readback_word == freq_word_f(cur_freq_reg));
            pending_next = 1'b0;
            if (cmd.ok)
            begin
                tuning_next = 1'b0;
            end
            else
            begin
                last_change_next = item.time_ms;
            end
        end
        else
        begin
            if ((item.requested_freq_mhz != cur_freq_reg) && gap_ok)
            begin
                last_change_next = item.time_ms;
                cur_freq_next    = item.requested_freq_mhz;
                pending_next     = 1'b0;
                if (item.requested_freq_mhz == pd_code_reg)
                begin
                    cmd.op            = rtfs_pkg::CMD_POWER_DOWN;
                    powered_down_next = 1'b1;
                    tuning_next       = 1'b0;
                end
                else
                begin
                    cmd.op            = powered_down_reg ? rtfs_pkg::CMD_WAKE
                                                         : rtfs_pkg::CMD_FREQ;
                    powered_down_next = 1'b0;
                    tuning_next       = 1'b1;
                end
            end
            else if (tuning_reg && wait_ok)
            begin
                last_change_next = item.time_ms;
                pending_next     = 1'b1;
                cmd.op           = rtfs_pkg::CMD_READ;
            end
            // rssi follows the tuning state after this tick
            if (!tuning_next)
            begin
                cmd.rssi = item.adc_sample[11] ? 8'hFF : item.adc_sample[10:3];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_gap_reg    <= 10'd30;
            tune_wait_reg  <= 10'd35;
            pd_code_reg    <= 13'd0;
            setup_word_reg <= 20'd855539;
        end
        else if (write_enable)
        begin
            unique case (rtfs_pkg::cfg_index_t'(write_index))
                rtfs_pkg::CFG_BUS_GAP:         bus_gap_reg    <= write_data[9:0];
                rtfs_pkg::CFG_TUNE_WAIT:       tune_wait_reg  <= write_data[9:0];
                rtfs_pkg::CFG_POWER_DOWN_CODE: pd_code_reg    <= write_data[12:0];
                rtfs_pkg::CFG_SETUP_POWER:     setup_word_reg <= write_data;
                default:                       bus_gap_reg    <= bus_gap_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_freq_reg     <= 13'd0;
            last_change_reg  <= 32'd0;
            tuning_reg       <= 1'b0;
            powered_down_reg <= 1'b1;
            pending_reg      <= 1'b0;
        end
        else if (cmd_push)
        begin
            cur_freq_reg     <= cur_freq_next;
            last_change_reg  <= last_change_next;
            tuning_reg       <= tuning_next;
            powered_down_reg <= powered_down_next;
            pending_reg      <= pending_next;
        end
    end

endmodule

@@ rtl/rtfs_cmd_fifo.sv @@
`timescale 1ns / 1ps

module rtfs_cmd_fifo
#(
    parameter int unsigned DEPTH = rtfs_pkg::CMD_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  rtfs_pkg::cmd_t      wr_data,
    input  logic                rd_en,
    output rtfs_pkg::cmd_t      rd_data,
    output rtfs_pkg::q_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rtfs_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/rtfs_back.sv @@
`timescale 1ns / 1ps

module rtfs_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  rtfs_pkg::cmd_t      cmd,
    input  rtfs_pkg::q_status_t q_stat,
    output logic                cmd_pop,
    output logic                empty,
    input  logic                pop,
    output rtfs_pkg::result_t   result
);

    rtfs_pkg::result_t out_reg;
    rtfs_pkg::result_t res;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        step_reg, step_next;
    logic              emit;

    assign empty   = !out_valid_reg;
    assign result  = out_reg;
    assign emit    = !q_stat.empty && (!out_valid_reg || pop);
    assign cmd_pop = emit && res.last;

    // one result per step of the current command
    always_comb
    begin
        res            = '0;
        res.rssi_level = cmd.rssi;
        case (cmd.op)
            rtfs_pkg::CMD_NONE:
            begin
                res.last = 1'b1;
            end
            rtfs_pkg::CMD_POWER_DOWN:
            begin
                res.frame_valid   = 1'b1;
                res.frame_address = rtfs_pkg::ADDR_POWER;
                res.frame_write   = 1'b1;
                res.frame_data    = rtfs_pkg::PD_WORD;
                res.last          = 1'b1;
            end
            rtfs_pkg::CMD_WAKE:
            begin
                res.frame_valid = 1'b1;
                res.frame_write = 1'b1;
                if (step_reg == 2'd0)
                begin
                    res.frame_address = rtfs_pkg::ADDR_RESET;
                end
                else if (step_reg == 2'd1)
                begin
                    res.frame_address = rtfs_pkg::ADDR_POWER;
                    res.frame_data    = cmd.power_word;
                end
                else
                begin
                    res.frame_address = rtfs_pkg::ADDR_FREQ;
                    res.frame_data    = {4'd0, cmd.freq_word};
                    res.last          = 1'b1;
                end
            end
            rtfs_pkg::CMD_FREQ:
            begin
                res.frame_valid   = 1'b1;
                res.frame_address = rtfs_pkg::ADDR_FREQ;
                res.frame_write   = 1'b1;
                res.frame_data    = {4'd0, cmd.freq_word};
                res.last          = 1'b1;
            end
            rtfs_pkg::CMD_READ:
            begin
                res.frame_valid   = 1'b1;
                res.frame_address = rtfs_pkg::ADDR_FREQ;
                res.last          = 1'b1;
            end
            rtfs_pkg::CMD_VERIFY:
            begin
                res.rssi_level  = 8'd0;
                res.verify_done = 1'b1;
                res.verify_ok   = cmd.ok;
                res.last        = 1'b1;
            end
            default:
            begin
                res.last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            step_next      = res.last ? 2'd0 : step_reg + 2'd1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

endmodule

@@ rtl/rx_tuner_frame_sequencer_top.sv @@
// receiver synthesizer frame sequencer
// input queue side: item is taken at a clock edge with push high and full low;
//   kind 0 is a millisecond tick, kind 1 carries readback data
// result queue side: the oldest result sits on result while empty is low and
//   is taken at a clock edge with pop high
// config: write_enable, write_index, write_data; a register is written on any
//   edge with write_enable high, no wait
// the front classifies each item and updates the tuning state in the cycle it
//   is taken, then queues one command; a readback with no read pending is
//   dropped and gives no result
// the back expands a command into one to three results, one per cycle into an
//   output register while it is empty or being popped
// an item's command is registered in the command queue, and its first result then in the output register
// throughput: one item per cycle while the command queue has room; results leave
//   at one per cycle while the receiver pops, so a wake-up item holds the back for three results
// receiver stall: results wait in the output register, the command queue
//   fills, then full rises; no result is lost
// reset: queues empty, registers at their defaults, receiver marked powered down
`timescale 1ns / 1ps
`include "rx_tuner_frame_sequencer_top_macros.svh"

module rx_tuner_frame_sequencer_top
#(
    parameter int unsigned CMD_DEPTH = rtfs_pkg::CMD_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  rtfs_pkg::item_t                  item,
    output logic                             empty,
    input  logic                             pop,
    output rtfs_pkg::result_t                result,
    input  logic                             write_enable,
    input  logic [rtfs_pkg::CFG_IDX_W-1:0]   write_index,
    input  logic [rtfs_pkg::CFG_DATA_W-1:0]  write_data
);

    rtfs_pkg::q_status_t q_stat;
    rtfs_pkg::cmd_t      cmd_in;
    rtfs_pkg::cmd_t      cmd_head;
    logic                cmd_push;
    logic                cmd_pop;

    rtfs_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .item         (item),
        .write_enable (write_enable),
        .write_index  (write_index),
        .write_data   (write_data),
        .q_stat       (q_stat),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    rtfs_cmd_fifo #(.DEPTH(CMD_DEPTH)) u_cmd_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .status  (q_stat)
    );

    rtfs_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_head),
        .q_stat  (q_stat),
        .cmd_pop (cmd_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    `RTFS_ASSERT_IMP(a_verify_shape, clk, rst_n, !empty && result.verify_done, !result.frame_valid && result.last && (result.rssi_level == 8'd0), "verify result malformed")

    `RTFS_ASSERT_IMP(a_read_frame, clk, rst_n, !empty && result.frame_valid && !result.frame_write, (result.frame_address == rtfs_pkg::ADDR_FREQ) && result.last && (result.frame_data == 20'd0), "read frame malformed")

    `RTFS_ASSERT_IMP(a_reset_not_last, clk, rst_n, !empty && result.frame_valid && (result.frame_address == rtfs_pkg::ADDR_RESET), !result.last, "reset frame ended a sequence")

    `RTFS_ASSERT_NEXT(a_reset_then_power, clk, rst_n, !empty && pop && result.frame_valid && (result.frame_address == rtfs_pkg::ADDR_RESET), !empty && (result.frame_address == rtfs_pkg::ADDR_POWER), "power frame did not follow reset frame")

endmodule
